// File: design/ftfr_pkg.sv
package ftfr_pkg;

  localparam int unsigned FlowEntries = 32;
  localparam int unsigned IdxW = $clog2(FlowEntries);
  localparam int unsigned MaxReports = 32;
  localparam int unsigned RepCntW = $clog2(MaxReports + 1);
  localparam logic [15:0] EtherIpv4 = 16'h0800;
  localparam logic [7:0] ProtoTcp = 8'd6;
  localparam logic [7:0] ProtoUdp = 8'd17;
  localparam logic [7:0] IdleReset = 8'd5;
  localparam logic [39:0] BytesMax = 40'hFF_FFFF_FFFF;
  localparam int unsigned OutW = 149;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_REPORT = 2'd1,
    KIND_END    = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_NOT_IPV4  = 3'd0,
    ST_FRAGMENT  = 3'd1,
    ST_OTHER     = 3'd2,
    ST_UPDATED   = 3'd3,
    ST_CREATED   = 3'd4,
    ST_FULL      = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    OP_STATUS = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_TICK   = 2'd2
  } op_e;

  typedef struct packed {
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } key_t;

  // classified work handed from front to back
  typedef struct packed {
    op_e         op;
    status_e     status;
    key_t        key;
    logic [15:0] len;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOOKUP,
    BK_MATCH,
    BK_STATUS,
    BK_FREE,
    BK_WALK,
    BK_END
  } back_e;

endpackage

// File: design/ftfr_front.sv
module ftfr_front import ftfr_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           command_i,
  input  logic [15:0]    ether_type_i,
  input  logic           more_fragments_i,
  input  key_t           key_i,
  input  logic [15:0]    frame_length_i,
  output logic           job_valid_o,
  input  logic           job_ready_i,
  output job_t           job_o
);

  // two-entry queue
  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  job_t       job_d;
  logic       push, pop;

  always_comb begin
    job_d = '0;
    job_d.key = key_i;
    job_d.len = frame_length_i;
    job_d.op = OP_STATUS;
    priority if (command_i) begin
      job_d.op = OP_TICK;
    end else if (ether_type_i != EtherIpv4) begin
      job_d.status = ST_NOT_IPV4;
    end else if (more_fragments_i) begin
      job_d.status = ST_FRAGMENT;
    end else if (key_i.protocol != ProtoTcp && key_i.protocol != ProtoUdp) begin
      job_d.status = ST_OTHER;
    end else begin
      job_d.op = OP_LOOKUP;
    end
  end

  assign in_ready_o  = cnt_q != 2'd2;
  assign push        = in_valid_i && in_ready_o;
  assign job_valid_o = cnt_q != 2'd0;
  assign pop         = job_valid_o && job_ready_i;
  assign job_o       = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= job_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: design/ftfr_back.sv
module ftfr_back import ftfr_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [7:0]     cfg_wdata_i,
  input  logic           job_valid_i,
  output logic           job_ready_o,
  input  job_t           job_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [OutW-1:0] out_data_o,
  output logic           out_last_o
);

  logic [7:0]             idle_ticks_q;
  logic [FlowEntries-1:0] valid_q;
  key_t                   key_q [FlowEntries];
  logic [7:0]             idle_q [FlowEntries];
  logic [39:0]            bytes_q [FlowEntries];

  back_e state_q, state_d;
  job_t  job_q;
  logic [FlowEntries-1:0] hit_q;
  logic [IdxW-1:0] idx_q;
  logic [RepCntW-1:0] rep_q;

  logic out_v_q;
  logic [OutW-1:0] out_d_q, out_d_d;
  logic out_l_q;
  logic out_free;

  logic [FlowEntries-1:0] hit_vec;
  logic [IdxW-1:0] hit_idx, free_idx;
  logic hit_any, free_any;
  logic [40:0] sum;
  logic rep_due;
  logic emit;
  kind_e emit_kind;
  status_e emit_status;
  logic emit_flow, emit_last;

  assign out_free = !out_v_q || out_ready_i;
  assign job_ready_o = state_q == BK_IDLE;

  // parallel key match, registered
  always_comb begin
    for (int i = 0; i < FlowEntries; i++) begin
      hit_vec[i] = valid_q[i] && key_q[i] == job_q.key;
    end
  end

  always_comb begin
    hit_idx = '0;
    free_idx = '0;
    hit_any = 1'b0;
    free_any = 1'b0;
    for (int i = FlowEntries - 1; i >= 0; i--) begin
      if (hit_q[i]) begin
        hit_idx = IdxW'(i);
        hit_any = 1'b1;
      end
      if (!valid_q[i]) begin
        free_idx = IdxW'(i);
        free_any = 1'b1;
      end
    end
  end

  assign sum = {1'b0, bytes_q[hit_idx]} + {25'd0, job_q.len};

  assign rep_due = valid_q[idx_q] && bytes_q[idx_q] != '0 &&
                   rep_q < RepCntW'(MaxReports);

  always_comb begin
    state_d = state_q;
    emit = 1'b0;
    emit_kind = KIND_STATUS;
    emit_status = job_q.status;
    emit_flow = 1'b0;
    emit_last = 1'b1;
    unique case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          unique case (job_i.op)
            OP_LOOKUP: state_d = BK_LOOKUP;
            OP_TICK:   state_d = BK_FREE;
            default:   state_d = BK_STATUS;
          endcase
        end
      end
      // wait for the match vector of the new key
      BK_LOOKUP: state_d = BK_MATCH;
      BK_MATCH: begin
        if (out_free) begin
          emit = 1'b1;
          priority if (hit_any) emit_status = ST_UPDATED;
          else if (free_any) emit_status = ST_CREATED;
          else emit_status = ST_FULL;
          state_d = BK_IDLE;
        end
      end
      BK_STATUS: begin
        if (out_free) begin
          emit = 1'b1;
          state_d = BK_IDLE;
        end
      end
      BK_FREE: state_d = BK_WALK;
      BK_WALK: begin
        if (rep_due) begin
          if (out_free) begin
            emit = 1'b1;
            emit_kind = KIND_REPORT;
            emit_status = ST_NOT_IPV4;
            emit_flow = 1'b1;
            emit_last = 1'b0;
            if (idx_q == IdxW'(FlowEntries - 1)) state_d = BK_END;
          end
        end else if (idx_q == IdxW'(FlowEntries - 1)) begin
          state_d = BK_END;
        end
      end
      BK_END: begin
        if (out_free) begin
          emit = 1'b1;
          emit_kind = KIND_END;
          emit_status = ST_NOT_IPV4;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    out_d_d = '0;
    out_d_d[1:0] = emit_kind;
    out_d_d[4:2] = emit_status;
    if (emit_flow) begin
      out_d_d[12:5] = key_q[idx_q].protocol;
      out_d_d[44:13] = key_q[idx_q].src_addr;
      out_d_d[76:45] = key_q[idx_q].dst_addr;
      out_d_d[92:77] = key_q[idx_q].src_port;
      out_d_d[108:93] = key_q[idx_q].dst_port;
      out_d_d[148:109] = bytes_q[idx_q];
    end
  end

  // hold the walk on an entry whose report cannot leave yet
  logic walk_step;
  assign walk_step = state_q == BK_WALK && (!rep_due || out_free);

  always_ff @(posedge clk_i) begin
    if (state_q == BK_IDLE && job_valid_i) job_q <= job_i;
    hit_q <= hit_vec;
    if (state_q == BK_MATCH && out_free) begin
      if (hit_any) begin
        bytes_q[hit_idx] <= sum[40] ? BytesMax : sum[39:0];
        idle_q[hit_idx] <= idle_ticks_q;
      end else if (free_any) begin
        key_q[free_idx] <= job_q.key;
        bytes_q[free_idx] <= {24'd0, job_q.len};
        idle_q[free_idx] <= idle_ticks_q;
      end
    end
    if (walk_step && valid_q[idx_q]) begin
      bytes_q[idx_q] <= '0;
      if (idle_q[idx_q] != 8'd0) idle_q[idx_q] <= idle_q[idx_q] - 8'd1;
    end
    if (emit) begin
      out_d_q <= out_d_d;
      out_l_q <= emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      idle_ticks_q <= IdleReset;
      valid_q <= '0;
      idx_q <= '0;
      rep_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) idle_ticks_q <= cfg_wdata_i;
      if (state_q == BK_MATCH && out_free && !hit_any && free_any) valid_q[free_idx] <= 1'b1;
      if (state_q == BK_FREE) begin
        for (int i = 0; i < FlowEntries; i++) begin
          if (idle_q[i] == 8'd0) valid_q[i] <= 1'b0;
        end
        idx_q <= '0;
        rep_q <= '0;
      end
      if (walk_step) idx_q <= idx_q + IdxW'(1);
      if (emit && emit_flow) rep_q <= rep_q + RepCntW'(1);
      if (emit) out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o = out_d_q;
  assign out_last_o = out_l_q;

endmodule

// File: design/five_tuple_flow_rate_table_top.sv
// Five-tuple flow byte meter with idle timeout, 32 entries. A packet beat is
// classified in the front stage and queued; the back stage takes a packet that
// passes classification through taking the job, a registered key match over all
// entries, then update and status beat, and one that does not through taking
// the job and its status beat. A tick beat frees idle entries, then walks every
// entry, one per cycle while no report waits on a stalled output, giving its
// reports and a final end beat (tlast).
module five_tuple_flow_rate_table_top import ftfr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [7:0]      cfg_wdata_i,     // idle_ticks
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic            s_axis_tuser,    // command
  // ether_type, more_fragments, protocol, src_addr, dst_addr,
  // src_port, dst_port, frame_length, zero pad
  input  logic [143:0]    s_axis_tdata,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [1:0]      m_axis_tuser,    // kind
  // status, flow_protocol, flow_src_addr, flow_dst_addr,
  // flow_src_port, flow_dst_port, interval_bytes, zero pad
  output logic [151:0]    m_axis_tdata,
  output logic            m_axis_tlast
);

  logic job_valid, job_ready;
  job_t job;
  key_t key;
  logic [OutW-1:0] out_data;

  assign key.protocol = s_axis_tdata[24:17];
  assign key.src_addr = s_axis_tdata[56:25];
  assign key.dst_addr = s_axis_tdata[88:57];
  assign key.src_port = s_axis_tdata[104:89];
  assign key.dst_port = s_axis_tdata[120:105];

  ftfr_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .command_i(s_axis_tuser), .ether_type_i(s_axis_tdata[15:0]),
    .more_fragments_i(s_axis_tdata[16]), .key_i(key),
    .frame_length_i(s_axis_tdata[136:121]),
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  ftfr_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_data_o(out_data), .out_last_o(m_axis_tlast)
  );

  assign m_axis_tuser = out_data[1:0];
  assign m_axis_tdata = {5'd0, out_data[OutW-1:2]};

endmodule

// File: design/ftfr_checker.sv
module ftfr_checker import ftfr_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [1:0]   m_axis_tuser,
  input logic [151:0] m_axis_tdata,
  input logic         m_axis_tlast
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed under stall");

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser != KIND_REPORT)))
    else $error("tlast does not match kind");

  a_report_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_REPORT |-> m_axis_tdata[2:0] == 3'd0 &&
      m_axis_tdata[146:107] != 40'd0)
    else $error("bad flow report");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= KIND_END)
    else $error("bad kind");

endmodule

bind five_tuple_flow_rate_table_top ftfr_checker u_chk (.*);
